// ----- design/actr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actr_pkg
// Shared types, constants and AES functions for the counter-mode core.
// ----------------------------------------------------------------------------
package actr_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;
    localparam logic [2:0] REG_CTR   = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic ks_init;   // load key words and restart rcon
        logic ks_step;   // derive next key word
        logic ks_sub;    // derive step uses plain SubWord
        logic ks_rot;    // derive step uses RotWord and rcon
        logic rd_load;   // load counter block with first round key
        logic rd_step;   // one middle round
        logic rd_final;  // last round and output XOR
        logic cnt_adv;   // advance or clear block index
    } t_ctrl;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // state is 128 bits, block byte 0 in bits 127:120
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8*(c*4 + r) -: 8] = sbox(s[127 - 8*(((c + r) % 4)*4 + r) -: 8]);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            o[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            o[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            o[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            o[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

endpackage

// ----- design/actr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actr_ctrl
// Sequencer: key expansion into the schedule memory, then the rounds.
// ----------------------------------------------------------------------------
module actr_ctrl import actr_pkg::*; #(
    parameter int KEY_WORDS = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    output logic   o_valid,
    input  logic   i_stall,
    output t_ctrl  o_ctrl,
    output logic [$clog2(4*(KEY_WORDS+7))-1:0] o_widx,
    output logic [$clog2(KEY_WORDS+7)-1:0]     o_round
);
    localparam int NR     = KEY_WORDS + 6;
    localparam int SWORDS = 4 * (NR + 1);
    localparam int WW     = $clog2(4*(KEY_WORDS+7));
    localparam int RW     = $clog2(KEY_WORDS+7);

    typedef enum logic [1:0] {S_IDLE, S_KEYS, S_RNDS, S_DONE} t_state;

    t_state          r_state, n_state;
    logic [WW-1:0]   r_widx, n_widx;
    logic [RW-1:0]   r_round, n_round;
    logic [3:0]      r_mod, n_mod;     // word index modulo KEY_WORDS
    logic            r_valid, n_valid;
    logic            w_accept, w_take;

    assign w_accept = (r_state == S_IDLE) && i_valid;
    assign w_take   = r_valid && !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_widx   = r_widx;
    assign o_round  = r_round;

    // command decode
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.ks_init  = w_accept;
        o_ctrl.ks_step  = (r_state == S_KEYS);
        o_ctrl.ks_rot   = (r_mod == 4'd0);
        o_ctrl.ks_sub   = (KEY_WORDS > 6) && (r_mod == 4'd4);
        o_ctrl.rd_load  = (r_state == S_KEYS) && (r_widx == WW'(SWORDS - 1));
        o_ctrl.rd_step  = (r_state == S_RNDS) && (r_round != RW'(NR));
        o_ctrl.rd_final = (r_state == S_RNDS) && (r_round == RW'(NR));
        o_ctrl.cnt_adv  = o_ctrl.rd_final;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_widx  = r_widx;
        n_round = r_round;
        n_mod   = r_mod;
        n_valid = r_valid && !w_take;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_KEYS;
                    n_widx  = WW'(KEY_WORDS);
                    n_mod   = '0;
                end
            end
            S_KEYS: begin
                n_widx = r_widx + 1'b1;
                n_mod  = (r_mod == 4'(KEY_WORDS - 1)) ? '0 : r_mod + 1'b1;
                if (r_widx == WW'(SWORDS - 1)) begin
                    n_state = S_RNDS;
                    n_round = RW'(1);
                end
            end
            S_RNDS: begin
                n_round = r_round + 1'b1;
                if (r_round == RW'(NR)) begin
                    n_state = S_DONE;
                    n_valid = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_valid || w_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_widx  <= '0;
            r_round <= '0;
            r_mod   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_widx  <= n_widx;
            r_round <= n_round;
            r_mod   <= n_mod;
        end
    end
endmodule

// ----- design/actr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actr_dp
// Datapath: key schedule memory, round register, block index, output.
// ----------------------------------------------------------------------------
module actr_dp import actr_pkg::*; #(
    parameter int KEY_WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic [$clog2(4*(KEY_WORDS+7))-1:0] i_widx,
    input  logic [$clog2(KEY_WORDS+7)-1:0]     i_round,
    input  logic [63:0] i_key_word_0,
    input  logic [63:0] i_key_word_1,
    input  logic [63:0] i_key_word_2,
    input  logic [63:0] i_key_word_3,
    input  logic [63:0] i_nonce,
    input  logic [63:0] i_initial_counter,
    input  logic [63:0] i_data_hi,
    input  logic [63:0] i_data_lo,
    input  logic        i_last_block,
    output logic [63:0] o_out_hi,
    output logic [63:0] o_out_lo
);
    localparam int NR = KEY_WORDS + 6;
    localparam int RW = $clog2(KEY_WORDS+7);

    logic [255:0]           w_key;
    logic [32*KEY_WORDS-1:0] r_win;     // last KEY_WORDS schedule words, newest low
    logic [31:0]            w_t, w_new;
    logic [7:0]             r_rcon;
    logic [127:0]           r_rk [NR+1]; // round keys: the initial key and one per round
    logic [127:0]           r_cur;       // round key being assembled
    logic [127:0]           r_state;
    logic [127:0]           w_ss;
    logic [63:0]            r_index;
    logic [63:0]            r_dhi, r_dlo;
    logic                   r_last;

    assign w_key = {i_key_word_0, i_key_word_1, i_key_word_2, i_key_word_3};

    // one schedule word per cycle
    always_comb begin
        w_t = r_win[31:0];
        if (i_ctrl.ks_rot)
            w_t = sub_word({w_t[23:0], w_t[31:24]}) ^ {r_rcon, 24'h0};
        else if (i_ctrl.ks_sub)
            w_t = sub_word(w_t);
        w_new = r_win[32*KEY_WORDS-1 -: 32] ^ w_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ks_init) begin
            for (int k = 0; k < KEY_WORDS; k++)
                r_win[32*k +: 32] <= w_key[255 - 32*(KEY_WORDS-1-k) -: 32];
            r_rcon <= 8'h01;
            for (int k = 0; k < KEY_WORDS; k++)
                r_cur[127 - 32*(k % 4) -: 32] <= w_key[255 - 32*k -: 32];
            for (int k = 0; k < KEY_WORDS; k++)
                if (k % 4 == 3)
                    r_rk[k/4] <= {w_key[255 - 32*(k-3) -: 32],
                        w_key[255 - 32*(k-2) -: 32], w_key[255 - 32*(k-1) -: 32],
                        w_key[255 - 32*k -: 32]};
        end else if (i_ctrl.ks_step) begin
            r_win <= {r_win[32*KEY_WORDS-33:0], w_new};
            if (i_ctrl.ks_rot) r_rcon <= xtime(r_rcon);
            r_cur[127 - 32*i_widx[1:0] -: 32] <= w_new;
            if (i_widx[1:0] == 2'd3)
                r_rk[i_widx[$bits(i_widx)-1:2]] <= {r_cur[127:32], w_new};
        end
    end

    assign w_ss = sub_shift(r_state);

    // round register and output
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ks_init) begin
            r_dhi  <= i_data_hi;
            r_dlo  <= i_data_lo;
            r_last <= i_last_block;
        end
        if (i_ctrl.rd_load)
            r_state <= {i_nonce, i_initial_counter + r_index} ^ r_rk[0];
        else if (i_ctrl.rd_step)
            r_state <= mix_cols(w_ss) ^ r_rk[i_round];
        if (i_ctrl.rd_final) begin
            o_out_hi <= r_dhi ^ w_ss[127:64] ^ r_rk[RW'(NR)][127:64];
            o_out_lo <= r_dlo ^ w_ss[63:0]   ^ r_rk[RW'(NR)][63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_index <= '0;
        else if (i_ctrl.cnt_adv)
            r_index <= r_last ? 64'd0 : r_index + 64'd1;
    end
endmodule

// ----- design/aes_ctr_encrypt_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctr_encrypt_top
// AES counter-mode encryption, one 128-bit block per transfer.
//
// channel  direction  handshake            payload
// input    in         i_valid / o_stall    i_data_hi, i_data_lo, i_last_block
// output   out        o_valid / i_stall    o_out_hi, o_out_lo
// config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Each block runs 4*(Nr+1)-KEY_WORDS words of key expansion (one word per
// cycle through a single S-box word unit) plus Nr rounds, then holds the
// result until the output takes it and returns to the idle state before the
// next input transfer is accepted.
// Input is stalled while busy.
// Reset clears the block index, the controller and the configuration registers; no clearing pass.
// ----------------------------------------------------------------------------
module aes_ctr_encrypt_top import actr_pkg::*; #(
    parameter int KEY_WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_hi,
    input  logic [63:0] i_data_lo,
    input  logic        i_last_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_hi,
    output logic [63:0] o_out_lo
);
    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce, r_ctr;
    t_ctrl       w_ctrl;
    logic [$clog2(4*(KEY_WORDS+7))-1:0] w_widx;
    logic [$clog2(KEY_WORDS+7)-1:0]     w_round;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0;
            r_key3 <= '0; r_nonce <= '0; r_ctr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY0:  r_key0  <= i_cfg_data;
                REG_KEY1:  r_key1  <= i_cfg_data;
                REG_KEY2:  r_key2  <= i_cfg_data;
                REG_KEY3:  r_key3  <= i_cfg_data;
                REG_NONCE: r_nonce <= i_cfg_data;
                REG_CTR:   r_ctr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    actr_ctrl #(.KEY_WORDS(KEY_WORDS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_ctrl(w_ctrl),
        .o_widx(w_widx), .o_round(w_round)
    );

    actr_dp #(.KEY_WORDS(KEY_WORDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .i_widx(w_widx),
        .i_round(w_round), .i_key_word_0(r_key0), .i_key_word_1(r_key1),
        .i_key_word_2(r_key2), .i_key_word_3(r_key3), .i_nonce(r_nonce),
        .i_initial_counter(r_ctr), .i_data_hi(i_data_hi), .i_data_lo(i_data_lo),
        .i_last_block(i_last_block), .o_out_hi(o_out_hi), .o_out_lo(o_out_lo)
    );
endmodule
